// File: rtl/fram_pkg.sv
// Package for the frame rate anomaly monitor: ring sizing, field widths,
// operation, kind, alert and register codes, sequencer states and shared structs.
// No dependencies.
package fram_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int DIV_CW     = $clog2(FILL_W + 1);
    localparam int WIN_W      = 6;
    localparam int WIN_MS_W   = 16;
    localparam int THR_W      = 16;
    localparam int TIME_W     = 32;
    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 32;
    localparam int RATE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_MS_W-1:0] MS_PER_SEC = 16'd1000;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd1;
    localparam logic [THR_W-1:0] RATE_RESET   = 16'd1000;
    localparam logic [THR_W-1:0] BEACON_RESET = 16'd50;

    localparam logic OP_ANALYZE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [1:0] ANOM_NONE  = 2'd0;
    localparam logic [1:0] ANOM_RATE  = 2'd1;
    localparam logic [1:0] ANOM_FLOOD = 2'd2;

    localparam logic [1:0] SEV_NONE   = 2'd0;
    localparam logic [1:0] SEV_MEDIUM = 2'd1;
    localparam logic [1:0] SEV_HIGH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_WAIT,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic rd;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic [1:0]        anomaly;
        logic [1:0]        severity;
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] stamp_ms;
        logic [ADDR_W-1:0] source;
        logic [CNT_W-1:0]  total_count;
        logic [CNT_W-1:0]  management_count;
        logic [CNT_W-1:0]  control_count;
        logic [CNT_W-1:0]  data_count;
        logic [1:0]        latched_anomaly;
    } alert_t;

endpackage

// File: rtl/fram_if.sv
// Request, alert and configuration channel interfaces of the frame rate monitor.
// Depends on fram_pkg.
interface fram_in_if import fram_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [1:0]        frame_kind;
    logic              beacon;
    logic [TIME_W-1:0] arrival_ms;
    logic [ADDR_W-1:0] sender;

    modport source (output valid, op, frame_kind, beacon, arrival_ms, sender, input ready);
    modport sink (input valid, op, frame_kind, beacon, arrival_ms, sender, output ready);
endinterface

interface fram_out_if import fram_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        anomaly;
    logic [1:0]        severity;
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] stamp_ms;
    logic [ADDR_W-1:0] src_addr;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  management_count;
    logic [CNT_W-1:0]  control_count;
    logic [CNT_W-1:0]  data_count;
    logic [1:0]        latched_anomaly;

    modport source (output valid, anomaly, severity, rate, stamp_ms, src_addr, total_count,
                    management_count, control_count, data_count, latched_anomaly,
                    input ready);
    modport sink (input valid, anomaly, severity, rate, stamp_ms, src_addr, total_count,
                  management_count, control_count, data_count, latched_anomaly,
                  output ready);
endinterface

interface fram_cfg_if import fram_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fram_ring.sv
// Ring of arrival times: single-port memory with head pointer and fill count.
// Depends on fram_pkg.
module fram_ring import fram_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  ring_cmd_t         cmd,
    input  logic [TIME_W-1:0] wr_data,
    output logic [FILL_W-1:0] fill,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [RING_DEPTH];

    logic [RING_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TIME_W-1:0]  rd_data_reg;

    logic               full;
    logic [RING_AW-1:0] head_inc;
    logic [RING_AW-1:0] head_push;
    logic [FILL_W-1:0]  fill_push;
    logic [RING_AW:0]   addr_sum;
    logic [RING_AW-1:0] wr_addr;

    always_comb
    begin
        full     = (fill_reg == FILL_W'(RING_DEPTH));
        head_inc = (head_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        head_push = full ? head_inc : head_reg;
        fill_push = full ? FILL_W'(RING_DEPTH - 1) : fill_reg;
        addr_sum  = {1'b0, head_push} + (RING_AW + 1)'(fill_push);
        if (addr_sum >= (RING_AW + 1)'(RING_DEPTH))
        begin
            wr_addr = RING_AW'(addr_sum - (RING_AW + 1)'(RING_DEPTH));
        end
        else
        begin
            wr_addr = addr_sum[RING_AW-1:0];
        end

        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (cmd.push)
        begin
            head_next = head_push;
            fill_next = fill_push + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next = head_inc;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign fill    = fill_reg;
    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fram_div.sv
// Serial restoring divider: fill count over window seconds, one quotient bit a cycle.
// Depends on fram_pkg.
module fram_div import fram_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FILL_W-1:0] dividend,
    input  logic [WIN_W-1:0]  divisor,
    output logic              done,
    output logic [FILL_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [FILL_W-1:0] quot_reg, quot_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [WIN_W-1:0]  dvs_reg, dvs_next;

    logic [WIN_W:0]    trial;
    logic [WIN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, quot_reg[FILL_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(FILL_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[FILL_W-2:0], ge};
            rem_next  = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: rtl/frame_rate_anomaly_monitor.sv
// Top level of the frame rate anomaly monitor: sequencer, counters, registers, result stage.
// Depends on fram_pkg, fram_if, fram_ring and fram_div.
//
// One request on the frame channel is either a frame to analyze or a clear. A frame is
// counted by kind, its arrival time is pushed into a ring of RING_DEPTH times, expired
// times are popped from the front, and the rate is the ring fill divided by the window in
// seconds; a rate above rate_threshold raises a high-rate alert, otherwise a beacon frame
// advances the beacon counter, which raises a beacon-flood alert when it passes
// beacon_threshold. One result leaves on the alert channel per request. The block takes
// one request at a time: a frame pushes its time, pops each expired time from the front
// and then runs the divider; each pop is a read of the single-port ring memory plus
// an age compare, and the divider resolves one quotient bit a cycle. The result stage
// holds one finished result, so the next request is taken while it waits; a request
// finishing while that result still waits holds in its last cycle until the result is
// taken. Configuration writes are always ready.
module frame_rate_anomaly_monitor import fram_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    fram_in_if.sink     frame,
    fram_out_if.source  alert,
    fram_cfg_if.sink    cfg
);

    state_t state_reg, state_next;

    logic [WIN_W-1:0]    window_reg;
    logic [THR_W-1:0]    rate_thr_reg;
    logic [THR_W-1:0]    beacon_thr_reg;

    logic                op_reg;
    logic                beacon_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [ADDR_W-1:0]   sender_reg;
    logic [WIN_W-1:0]    win_reg;
    logic [WIN_MS_W-1:0] win_ms_reg;

    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    mgmt_reg;
    logic [CNT_W-1:0]    ctrl_reg;
    logic [CNT_W-1:0]    data_reg;
    logic [CNT_W-1:0]    beacons_reg;
    logic [1:0]          latch_reg;
    logic [FILL_W-1:0]   quot_reg;

    alert_t              out_reg;
    logic                out_valid_reg;

    ring_cmd_t           ring_cmd;
    logic [FILL_W-1:0]   fill;
    logic [TIME_W-1:0]   rd_data;
    logic                div_start;
    logic                div_done;
    logic [FILL_W-1:0]   quotient;

    logic                accept;
    logic                slot_free;
    logic                expired;
    logic [TIME_W-1:0]   age;
    logic [WIN_W-1:0]    win_eff;
    logic                rate_high;
    logic [CNT_W-1:0]    beacons_inc;
    logic                flood;
    alert_t              result;

    assign accept    = frame.valid && frame.ready;
    assign slot_free = !out_valid_reg || alert.ready;
    assign win_eff   = (window_reg == '0) ? WIN_W'(1) : window_reg;
    assign age       = now_reg - rd_data;
    assign expired   = (age > TIME_W'(win_ms_reg)) && (fill != '0);

    fram_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .wr_data (now_reg),
        .fill    (fill),
        .rd_data (rd_data)
    );

    fram_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fill),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (frame.op == OP_CLEAR) ? ST_EVAL : ST_PUSH;
                end
            end
            ST_PUSH:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = expired ? ST_READ : ST_DIV;
            ST_DIV:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ring_cmd    = '0;
        div_start   = 1'b0;
        frame.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                frame.ready    = 1'b1;
                ring_cmd.clear = accept && (frame.op == OP_CLEAR);
            end
            ST_PUSH:  ring_cmd.push = 1'b1;
            ST_READ:  ring_cmd.rd = 1'b1;
            ST_CHECK: ring_cmd.pop = expired;
            ST_DIV:   div_start = 1'b1;
            default:
            begin
                ring_cmd  = '0;
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rate_high   = (32'(quot_reg) > 32'(rate_thr_reg));
        beacons_inc = beacons_reg + 1'b1;
        flood       = beacons_inc > CNT_W'(beacon_thr_reg);

        result                  = '0;
        result.total_count      = total_reg;
        result.management_count = mgmt_reg;
        result.control_count    = ctrl_reg;
        result.data_count       = data_reg;
        result.latched_anomaly  = latch_reg;
        if (op_reg == OP_ANALYZE)
        begin
            result.rate     = RATE_W'(quot_reg);
            result.stamp_ms = now_reg;
            result.source   = sender_reg;
            if (rate_high)
            begin
                result.anomaly         = ANOM_RATE;
                result.severity        = SEV_HIGH;
                result.latched_anomaly = ANOM_RATE;
            end
            else if (beacon_reg && flood)
            begin
                result.anomaly         = ANOM_FLOOD;
                result.severity        = SEV_MEDIUM;
                result.latched_anomaly = ANOM_FLOOD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WINDOW_RESET;
            rate_thr_reg   <= RATE_RESET;
            beacon_thr_reg <= BEACON_RESET;
            total_reg      <= '0;
            mgmt_reg       <= '0;
            ctrl_reg       <= '0;
            data_reg       <= '0;
            beacons_reg    <= '0;
            latch_reg      <= ANOM_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_WINDOW: window_reg <= cfg.data[WIN_W-1:0];
                    CFG_RATE:   rate_thr_reg <= cfg.data;
                    CFG_BEACON: beacon_thr_reg <= cfg.data;
                    default:    window_reg <= window_reg;
                endcase
            end

            if (accept)
            begin
                if (frame.op == OP_CLEAR)
                begin
                    total_reg <= '0;
                    mgmt_reg  <= '0;
                    ctrl_reg  <= '0;
                    data_reg  <= '0;
                    latch_reg <= ANOM_NONE;
                end
                else
                begin
                    total_reg <= total_reg + 1'b1;
                    case (frame.frame_kind)
                        KIND_MGMT: mgmt_reg <= mgmt_reg + 1'b1;
                        KIND_CTRL: ctrl_reg <= ctrl_reg + 1'b1;
                        KIND_DATA: data_reg <= data_reg + 1'b1;
                        default:   ;
                    endcase
                end
            end

            if (state_reg == ST_EVAL && slot_free)
            begin
                out_valid_reg <= 1'b1;
                latch_reg     <= result.latched_anomaly;
                if (op_reg == OP_ANALYZE && !rate_high && beacon_reg)
                begin
                    beacons_reg <= flood ? '0 : beacons_inc;
                end
            end
            else if (alert.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= frame.op;
            beacon_reg <= frame.beacon;
            now_reg    <= frame.arrival_ms;
            sender_reg <= frame.sender;
            win_reg    <= win_eff;
            win_ms_reg <= WIN_MS_W'(win_eff) * MS_PER_SEC;
            quot_reg   <= '0;
        end
        else if (state_reg == ST_WAIT && div_done)
        begin
            quot_reg <= quotient;
        end
        if (state_reg == ST_EVAL && slot_free)
        begin
            out_reg <= result;
        end
    end

    assign cfg.ready              = 1'b1;
    assign alert.valid            = out_valid_reg;
    assign alert.anomaly          = out_reg.anomaly;
    assign alert.severity         = out_reg.severity;
    assign alert.rate             = out_reg.rate;
    assign alert.stamp_ms         = out_reg.stamp_ms;
    assign alert.src_addr         = out_reg.source;
    assign alert.total_count      = out_reg.total_count;
    assign alert.management_count = out_reg.management_count;
    assign alert.control_count    = out_reg.control_count;
    assign alert.data_count       = out_reg.data_count;
    assign alert.latched_anomaly  = out_reg.latched_anomaly;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for frame_rate_anomaly_monitor: drives frame requests and register writes,
// tracks the expected alert of every accepted request and checks each alert field by field.
// Depends on fram_pkg, fram_if and the RTL of the block.
module tb_top;
    import fram_pkg::*;

    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int QUIET_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_PATTERN,
        STALL_RANDOM
    } stall_kind_t;

    class frame_tally;
        logic [WIN_W-1:0]  window_cfg;
        logic [THR_W-1:0]  rate_limit;
        logic [THR_W-1:0]  beacon_limit;
        logic [TIME_W-1:0] arrivals[$];
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  mgmt;
        logic [CNT_W-1:0]  ctrl;
        logic [CNT_W-1:0]  data_frames;
        logic [CNT_W-1:0]  beacons;
        logic [1:0]        latch;
        alert_t            pending_alerts[$];
        int                mismatches;

        function new();
            window_cfg   = WINDOW_RESET;
            rate_limit   = RATE_RESET;
            beacon_limit = BEACON_RESET;
            total        = '0;
            mgmt         = '0;
            ctrl         = '0;
            data_frames  = '0;
            beacons      = '0;
            latch        = ANOM_NONE;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_WINDOW: window_cfg = value[WIN_W-1:0];
                CFG_RATE:   rate_limit = value[THR_W-1:0];
                CFG_BEACON: beacon_limit = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic op, logic [1:0] kind, logic bcn,
                                   logic [TIME_W-1:0] now, logic [ADDR_W-1:0] src);
            alert_t            exp;
            int                win;
            logic [TIME_W-1:0] win_ms;
            exp = '0;
            if (op == OP_CLEAR)
            begin
                arrivals.delete();
                total       = '0;
                mgmt        = '0;
                ctrl        = '0;
                data_frames = '0;
                latch       = ANOM_NONE;
            end
            else
            begin
                total++;
                case (kind)
                    KIND_MGMT: mgmt++;
                    KIND_CTRL: ctrl++;
                    KIND_DATA: data_frames++;
                    default: ;
                endcase
                win = (window_cfg == '0) ? 1 : int'(window_cfg);
                win_ms = TIME_W'(win * MS_PER_SEC);
                // drop the oldest time when full, then retire expired ones
                if (arrivals.size() >= RING_DEPTH)
                    arrivals.delete(0);
                arrivals.insert(arrivals.size(), now);
                while (arrivals.size() > 0 && (now - arrivals[0]) > win_ms)
                    arrivals.delete(0);
                exp.rate     = RATE_W'(arrivals.size() / win);
                exp.stamp_ms = now;
                exp.source   = src;
                if (exp.rate > rate_limit)
                begin
                    exp.anomaly  = ANOM_RATE;
                    exp.severity = SEV_HIGH;
                    latch        = ANOM_RATE;
                end
                else if (bcn)
                begin
                    beacons++;
                    if (beacons > beacon_limit)
                    begin
                        exp.anomaly  = ANOM_FLOOD;
                        exp.severity = SEV_MEDIUM;
                        latch        = ANOM_FLOOD;
                        beacons      = '0;
                    end
                end
            end
            exp.total_count      = total;
            exp.management_count = mgmt;
            exp.control_count    = ctrl;
            exp.data_count       = data_frames;
            exp.latched_anomaly  = latch;
            pending_alerts.insert(pending_alerts.size(), exp);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("alert %s mismatch: expected %0h, got %0h", name, want, seen);
            end
        endfunction

        function void check_alert(alert_t got);
            alert_t exp;
            if (pending_alerts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected alert: %0h", got);
                return;
            end
            exp = pending_alerts[0];
            pending_alerts.delete(0);
            compare_field("anomaly", 64'(exp.anomaly), 64'(got.anomaly));
            compare_field("severity", 64'(exp.severity), 64'(got.severity));
            compare_field("rate", 64'(exp.rate), 64'(got.rate));
            compare_field("stamp_ms", 64'(exp.stamp_ms), 64'(got.stamp_ms));
            compare_field("source", 64'(exp.source), 64'(got.source));
            compare_field("total_count", 64'(exp.total_count), 64'(got.total_count));
            compare_field("management_count", 64'(exp.management_count),
                          64'(got.management_count));
            compare_field("control_count", 64'(exp.control_count), 64'(got.control_count));
            compare_field("data_count", 64'(exp.data_count), 64'(got.data_count));
            compare_field("latched_anomaly", 64'(exp.latched_anomaly),
                          64'(got.latched_anomaly));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fram_in_if  frame_ch();
    fram_out_if alert_ch();
    fram_cfg_if cfg_ch();

    frame_tally        tally;
    logic [TIME_W-1:0] clock_ms;
    int                quiet_cycles = 0;
    stall_kind_t       stall_mode;
    logic [15:0]       stall_pattern;
    logic [3:0]        pat_pos;
    int                mode_timer;

    frame_rate_anomaly_monitor i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_ch),
        .alert (alert_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alert_ch.ready <= 1'b0;
            stall_mode     <= STALL_NONE;
            stall_pattern  <= 16'hFFFF;
            pat_pos        <= '0;
            mode_timer     <= 0;
        end
        else
        begin
            if (mode_timer == 0)
            begin
                stall_mode    <= stall_kind_t'($urandom_range(0, 2));
                stall_pattern <= 16'($urandom) | 16'h0001;
                mode_timer    <= $urandom_range(50, 400);
            end
            else
                mode_timer <= mode_timer - 1;
            pat_pos <= pat_pos + 4'd1;
            case (stall_mode)
                STALL_PATTERN: alert_ch.ready <= stall_pattern[pat_pos];
                STALL_RANDOM:  alert_ch.ready <= ($urandom_range(0, 99) >= 40);
                default:       alert_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
                tally.note_request(frame_ch.op, frame_ch.frame_kind, frame_ch.beacon,
                                   frame_ch.arrival_ms, frame_ch.sender);
            if (alert_ch.valid && alert_ch.ready)
                tally.check_alert({alert_ch.anomaly, alert_ch.severity, alert_ch.rate,
                                   alert_ch.stamp_ms, alert_ch.src_addr, alert_ch.total_count,
                                   alert_ch.management_count, alert_ch.control_count,
                                   alert_ch.data_count, alert_ch.latched_anomaly});
        end
    end

    always @(posedge clk)
    begin
        if ((frame_ch.valid && frame_ch.ready) || (alert_ch.valid && alert_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_frame(logic op, logic [1:0] kind, logic bcn,
                              logic [TIME_W-1:0] t, logic [ADDR_W-1:0] src);
        frame_ch.valid      <= 1'b1;
        frame_ch.op         <= op;
        frame_ch.frame_kind <= kind;
        frame_ch.beacon     <= bcn;
        frame_ch.arrival_ms <= t;
        frame_ch.sender     <= src;
        do @(posedge clk); while (!frame_ch.ready);
    endtask

    task automatic hold_off(int cycles);
        frame_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (tally.pending_alerts.size() != 0);
    endtask

    task automatic set_regs(logic [CFG_DATA_W-1:0] win_d, logic [CFG_DATA_W-1:0] rate_d,
                            logic [CFG_DATA_W-1:0] bcn_d);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{CFG_WINDOW, CFG_RATE, CFG_BEACON};
        val = '{win_d, rate_d, bcn_d};
        foreach (idx[i])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
            tally.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int count, int step_max, int clear_pct, int jump_pct);
        int                burst_left;
        int                roll;
        logic              op;
        logic [63:0]       addr_bits;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < jump_pct)
                clock_ms = clock_ms - $urandom_range(1, 5000);
            else if (roll < 2 * jump_pct)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_ANALYZE;
            addr_bits = {$urandom, $urandom};
            send_frame(op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), clock_ms,
                       addr_bits[ADDR_W-1:0]);
            burst_left--;
            if ($urandom_range(0, 99) == 0)
                drain();
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 8));
            end
        end
    endtask

    initial
    begin
        logic [31:0] cfg_bits;
        tally = new();
        clock_ms = '0;
        frame_ch.valid      <= 1'b0;
        frame_ch.op         <= OP_ANALYZE;
        frame_ch.frame_kind <= KIND_MGMT;
        frame_ch.beacon     <= 1'b0;
        frame_ch.arrival_ms <= '0;
        frame_ch.sender     <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_WINDOW;
        cfg_ch.data         <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero window acts as one second
        set_regs(16'h0000, 16'd2, 16'd1);
        send_frame(OP_CLEAR, KIND_OTHER, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_frame(OP_ANALYZE, KIND_MGMT, 1'b1, 32'd0, 48'h0);
        send_frame(OP_ANALYZE, KIND_CTRL, 1'b1, 32'd1000, 48'hFFFF_FFFF_FFFF);
        send_frame(OP_ANALYZE, KIND_DATA, 1'b0, 32'd1000, 48'hAAAA_AAAA_AAAA);
        send_frame(OP_ANALYZE, KIND_OTHER, 1'b1, 32'd1001, 48'h5555_5555_5555);
        send_frame(OP_ANALYZE, KIND_DATA, 1'b0, 32'hFFFF_FFFF, 48'h8000_0000_0001);
        send_frame(OP_ANALYZE, KIND_MGMT, 1'b1, 32'h0000_0100, 48'h0000_0000_0001);
        send_frame(OP_ANALYZE, KIND_CTRL, 1'b0, 32'h0000_0050, 48'h7FFF_FFFF_FFFE);
        hold_off(3);
        send_frame(OP_CLEAR, KIND_MGMT, 1'b0, 32'h8000_0000, 48'h8000_0000_0000);
        send_frame(OP_ANALYZE, KIND_MGMT, 1'b1, 32'h7FFF_FFFF, 48'h0123_4567_89AB);
        send_frame(OP_ANALYZE, KIND_OTHER, 1'b1, 32'h8000_0000, 48'hFEDC_BA98_7654);
        send_frame(OP_ANALYZE, KIND_OTHER, 1'b0, 32'h8000_0000, 48'h0F0F_0F0F_0F0F);
        drain();
        set_regs(16'd60, 16'hFFFF, 16'hFFFF);
        send_frame(OP_ANALYZE, KIND_DATA, 1'b1, 32'h8000_0000, 48'hF0F0_F0F0_F0F0);
        send_frame(OP_ANALYZE, KIND_CTRL, 1'b1, 32'h8000_EA60, 48'h3333_3333_3333);
        send_frame(OP_ANALYZE, KIND_MGMT, 1'b1, 32'h8000_EA61, 48'hCCCC_CCCC_CCCC);
        clock_ms = 32'h8000_EA61;

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            cfg_bits = $urandom;
            case (phase)
                0:
                begin
                    set_regs(16'd1, 16'd0, 16'hFFFF);
                    run_phase(120, 600, 3, 3);
                end
                1:
                begin
                    // long window, tiny steps: fill the ring to saturation
                    set_regs(16'd60, 16'd15, 16'd3);
                    run_phase(1100, 2, 0, 0);
                end
                2:
                begin
                    clock_ms = 32'hFFFF_F000;
                    set_regs(16'($urandom_range(2, 10)), 16'($urandom_range(0, 8)),
                             16'($urandom_range(0, 5)));
                    run_phase(120, 300, 3, 2);
                end
                3:
                begin
                    set_regs(16'hFFC0, 16'hFFFF, 16'h0000);
                    run_phase(80, 200, 3, 2);
                end
                4:
                begin
                    set_regs(cfg_bits[15:0] | 16'h003F, 16'd4, 16'hFFFF);
                    run_phase(80, 100, 3, 2);
                end
                default:
                begin
                    set_regs(cfg_bits[15:0], 16'($urandom_range(0, 20)),
                             16'($urandom_range(0, 10)));
                    run_phase(80, 400, 3, 2);
                end
            endcase
        end

        drain();
        repeat (50) @(posedge clk);
        if (tally.pending_alerts.size() != 0)
        begin
            $display("%0d expected alerts never arrived", tally.pending_alerts.size());
            tally.mismatches += tally.pending_alerts.size();
        end
        if (tally.mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
